[design/rtu_pkg.sv]
// rtu_pkg: shared types and constants of the routing table unit
// used by every module of the unit; no dependencies
package rtu_pkg;

    localparam int NUM_NODES_DEF  = 8;
    localparam int NUM_TOPICS_DEF = 16;

    // fixed field widths of the message format
    localparam int MaskW  = 8;
    localparam int TopicW = 4;
    localparam int NodeW  = 3;
    localparam int CmdW   = 2;
    localparam int QueueDepth = 2;

    localparam logic [CmdW-1:0] CMD_PUBLISH   = 2'd0;
    localparam logic [CmdW-1:0] CMD_SUBSCRIBE = 2'd1;

    localparam logic [0:0] REG_NEIGHBOR_MASK = 1'b0;
    localparam logic [0:0] REG_SUB_KIND_MASK = 1'b1;

    typedef enum logic [1:0] {
        KIND_NOTIFY    = 2'd0,
        KIND_PUBLISH   = 2'd1,
        KIND_SUBSCRIBE = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    // one classified item waiting for fan-out
    typedef struct packed {
        logic              err;
        kind_t             kind_a;
        logic [MaskW-1:0]  a_mask;
        logic [MaskW-1:0]  b_mask;
        logic [TopicW-1:0] topic;
        logic [NodeW-1:0]  src;
    } job_t;

endpackage

[design/pubsub_broker_routing_table_unit.sv]
// pubsub_broker_routing_table_unit: top level of the routing table unit
// an accepted item passes through the job queue and the back end's job register before its
// first result is registered onto the outputs; the back end holds each job from its load until
// its last result, one result per cycle while out_ready allows; items with no result never enter the queue
// a 2-entry job queue lets the front keep accepting while results drain
// reset: config registers and both topic tables clear at once, no clearing pass
module pubsub_broker_routing_table_unit #(
    parameter int NUM_NODES  = rtu_pkg::NUM_NODES_DEF,
    parameter int NUM_TOPICS = rtu_pkg::NUM_TOPICS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [rtu_pkg::MaskW-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rtu_pkg::CmdW-1:0]   cmd,
    input  logic [rtu_pkg::TopicW-1:0] topic,
    input  logic [rtu_pkg::NodeW-1:0]  source_node,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rtu_pkg::NodeW-1:0]  dest_node,
    output logic [1:0]                 out_kind,
    output logic [rtu_pkg::TopicW-1:0] out_topic,
    output logic                       last_of_run
);

    logic          push;
    logic          q_full;
    logic          pop;
    logic          q_valid;
    rtu_pkg::job_t push_job;
    rtu_pkg::job_t q_job;

    rtu_front #(
        .NUM_NODES  (NUM_NODES),
        .NUM_TOPICS (NUM_TOPICS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .topic       (topic),
        .source_node (source_node),
        .q_full      (q_full),
        .push        (push),
        .job         (push_job)
    );

    rtu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .din     (push_job),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .dout    (q_job)
    );

    rtu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (q_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dest_node   (dest_node),
        .out_kind    (out_kind),
        .out_topic   (out_topic),
        .last_of_run (last_of_run)
    );

endmodule

[design/rtu_front.sv]
// rtu_front: accepts items, holds the config registers and both topic tables,
// classifies each item into a fan-out job; depends on rtu_pkg
module rtu_front #(
    parameter int NUM_NODES  = rtu_pkg::NUM_NODES_DEF,
    parameter int NUM_TOPICS = rtu_pkg::NUM_TOPICS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [rtu_pkg::MaskW-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rtu_pkg::CmdW-1:0]   cmd,
    input  logic [rtu_pkg::TopicW-1:0] topic,
    input  logic [rtu_pkg::NodeW-1:0]  source_node,
    input  logic                       q_full,
    output logic                       push,
    output rtu_pkg::job_t              job
);

    localparam int NodeLim = (NUM_NODES < rtu_pkg::MaskW) ? NUM_NODES : rtu_pkg::MaskW;
    // only topics the field can carry ever reach a row
    localparam int TopicSpan = 1 << rtu_pkg::TopicW;
    localparam int Rows = (NUM_TOPICS < TopicSpan) ? NUM_TOPICS : TopicSpan;
    localparam int RowW = $clog2(Rows);
    localparam logic [rtu_pkg::MaskW-1:0] NodeValid =
        rtu_pkg::MaskW'((1 << NodeLim) - 1);

    logic [rtu_pkg::MaskW-1:0] nbr_mask_reg;
    logic [rtu_pkg::MaskW-1:0] kind_mask_reg;
    logic [NodeLim-1:0]        sub_tab_reg [Rows];
    logic [NodeLim-1:0]        route_tab_reg [Rows];

    logic [RowW-1:0]           row;
    logic [rtu_pkg::MaskW-1:0] src_bit;
    logic [rtu_pkg::MaskW-1:0] nbr;
    logic [rtu_pkg::MaskW-1:0] sub_row;
    logic [rtu_pkg::MaskW-1:0] route_row;
    logic                      accept;
    logic                      sub_ok;

    // topic to row, folded at elaboration
    always_comb
    begin
        row = '0;
        for (int k = 0; k < TopicSpan; k++)
        begin
            if (topic == rtu_pkg::TopicW'(k))
            begin
                row = RowW'(k % Rows);
            end
        end
    end

    assign src_bit   = rtu_pkg::MaskW'(1) << source_node;
    assign nbr       = nbr_mask_reg & NodeValid;
    assign sub_row   = rtu_pkg::MaskW'(sub_tab_reg[row]);
    assign route_row = rtu_pkg::MaskW'(route_tab_reg[row]);
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign sub_ok    = (cmd == rtu_pkg::CMD_SUBSCRIBE) && ((nbr & src_bit) != '0);

    always_comb
    begin
        job.err    = 1'b0;
        job.kind_a = rtu_pkg::KIND_NOTIFY;
        job.a_mask = '0;
        job.b_mask = '0;
        job.topic  = topic;
        job.src    = source_node;
        case (cmd)
            rtu_pkg::CMD_PUBLISH:
            begin
                job.a_mask = sub_row;
                job.b_mask = route_row & ~src_bit;
            end
            rtu_pkg::CMD_SUBSCRIBE:
            begin
                if (sub_ok)
                begin
                    job.kind_a = rtu_pkg::KIND_SUBSCRIBE;
                    job.a_mask = nbr & ~src_bit;
                end
                else
                begin
                    job.err = 1'b1;
                end
            end
            default:
            begin
                job.err = 1'b1;
            end
        endcase
    end

    // items with nothing to send never enter the queue
    assign push = accept && (job.err || (job.a_mask != '0) || (job.b_mask != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbr_mask_reg  <= '0;
            kind_mask_reg <= '0;
            for (int r = 0; r < Rows; r++)
            begin
                sub_tab_reg[r]   <= '0;
                route_tab_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rtu_pkg::REG_NEIGHBOR_MASK: nbr_mask_reg  <= cfg_data;
                    rtu_pkg::REG_SUB_KIND_MASK: kind_mask_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && sub_ok)
            begin
                if ((kind_mask_reg & src_bit) != '0)
                begin
                    sub_tab_reg[row] <= sub_tab_reg[row] | src_bit[NodeLim-1:0];
                end
                else
                begin
                    route_tab_reg[row] <= route_tab_reg[row] | src_bit[NodeLim-1:0];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_err_no_masks: assert property (@(posedge clk) disable iff (!rst_n)
        push && job.err |-> (job.a_mask == '0) && (job.b_mask == '0))
        else $error("error job carries fan-out masks");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full && in_valid)
        else $error("push into full queue");
    a_masks_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((job.a_mask | job.b_mask) & ~NodeValid) == '0)
        else $error("destination beyond node range");
`endif

endmodule

[design/rtu_queue.sv]
// rtu_queue: short job queue between front and back
// depends on rtu_pkg for job_t and the queue depth
module rtu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rtu_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output rtu_pkg::job_t dout
);

    localparam int PtrW = (rtu_pkg::QueueDepth > 1) ? $clog2(rtu_pkg::QueueDepth) : 1;
    localparam int CntW = $clog2(rtu_pkg::QueueDepth + 1);

    rtu_pkg::job_t  mem_reg [rtu_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full    = count_reg == CntW'(rtu_pkg::QueueDepth);
    assign q_valid = count_reg != '0;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(rtu_pkg::QueueDepth - 1)) ?
                              '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(rtu_pkg::QueueDepth - 1)) ?
                              '0 : rd_ptr_reg + PtrW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(rtu_pkg::QueueDepth))
        else $error("queue count out of range");
`endif

endmodule

[design/rtu_back.sv]
// rtu_back: takes jobs from the queue and emits one result per cycle while out_ready
// allows, lowest node id first within each mask (a_mask before b_mask); depends on rtu_pkg
module rtu_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  rtu_pkg::job_t              q_job,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rtu_pkg::NodeW-1:0]  dest_node,
    output logic [1:0]                 out_kind,
    output logic [rtu_pkg::TopicW-1:0] out_topic,
    output logic                       last_of_run
);

    rtu_pkg::job_t             cur_reg;
    logic                      busy_reg;
    logic                      out_valid_reg;
    logic [rtu_pkg::NodeW-1:0] dest_reg;
    rtu_pkg::kind_t            kind_reg;
    logic [rtu_pkg::TopicW-1:0] topic_reg;
    logic                      last_reg;

    logic                      adv;
    logic                      emit;
    logic                      use_a;
    logic [rtu_pkg::MaskW-1:0] sel;
    logic [rtu_pkg::MaskW-1:0] low_bit;
    logic [rtu_pkg::NodeW-1:0] low_idx;
    logic [rtu_pkg::MaskW-1:0] a_next;
    logic [rtu_pkg::MaskW-1:0] b_next;
    logic                      last_next;
    rtu_pkg::kind_t            kind_next;
    logic [rtu_pkg::NodeW-1:0] dest_next;

    assign adv   = !out_valid_reg || out_ready;
    assign emit  = busy_reg && adv;
    assign pop   = !busy_reg && q_valid;
    assign use_a = cur_reg.a_mask != '0;
    assign sel   = use_a ? cur_reg.a_mask : cur_reg.b_mask;
    // isolate lowest set bit
    assign low_bit = sel & (~sel + rtu_pkg::MaskW'(1));

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < rtu_pkg::MaskW; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = rtu_pkg::NodeW'(i);
            end
        end
    end

    always_comb
    begin
        a_next = cur_reg.a_mask;
        b_next = cur_reg.b_mask;
        if (use_a)
        begin
            a_next = cur_reg.a_mask & ~low_bit;
        end
        else
        begin
            b_next = cur_reg.b_mask & ~low_bit;
        end
        if (cur_reg.err)
        begin
            last_next = 1'b1;
            kind_next = rtu_pkg::KIND_ERROR;
            dest_next = cur_reg.src;
        end
        else
        begin
            last_next = (a_next == '0) && (b_next == '0);
            kind_next = use_a ? cur_reg.kind_a : rtu_pkg::KIND_PUBLISH;
            dest_next = low_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_job;
        end
        else if (emit)
        begin
            cur_reg.a_mask <= a_next;
            cur_reg.b_mask <= b_next;
        end
        if (emit)
        begin
            dest_reg  <= dest_next;
            kind_reg  <= kind_next;
            topic_reg <= cur_reg.topic;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && last_next)
            begin
                busy_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign dest_node   = dest_reg;
    assign out_kind    = kind_reg;
    assign out_topic   = topic_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == rtu_pkg::KIND_ERROR) |-> last_of_run)
        else $error("error result not marked last");
    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cur_reg.err || (cur_reg.a_mask != '0) || (cur_reg.b_mask != '0))
        else $error("busy with nothing left to send");
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_next |=> !busy_reg)
        else $error("job not released after its last result");
`endif

endmodule

[tb/pubsub_broker_routing_table_unit_test.sv]
// pubsub_broker_routing_table_unit_test: self-checking testbench of the broker routing table
// predicts every outgoing item from its own copy of the topic tables and masks
// depends on rtu_pkg and pubsub_broker_routing_table_unit
`timescale 1ns / 1ps

module pubsub_broker_routing_table_unit_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 80;
    localparam int REPORT_LIMIT   = 10;

    // message types the block rejects
    localparam logic [rtu_pkg::CmdW-1:0] CMD_BAD_LO = 2'd2;
    localparam logic [rtu_pkg::CmdW-1:0] CMD_BAD_HI = 2'd3;

    typedef struct packed {
        logic [rtu_pkg::NodeW-1:0]  dest;
        rtu_pkg::kind_t             kind;
        logic [rtu_pkg::TopicW-1:0] topic;
        logic                       is_last;
    } out_msg_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [0:0]                 cfg_index;
    logic [rtu_pkg::MaskW-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [rtu_pkg::CmdW-1:0]   cmd;
    logic [rtu_pkg::TopicW-1:0] topic;
    logic [rtu_pkg::NodeW-1:0]  source_node;
    logic                       out_valid;
    logic                       out_ready;
    logic [rtu_pkg::NodeW-1:0]  dest_node;
    logic [1:0]                 out_kind;
    logic [rtu_pkg::TopicW-1:0] out_topic;
    logic                       last_of_run;

    // broker state as the testbench sees it
    logic [rtu_pkg::MaskW-1:0] sub_tbl [rtu_pkg::NUM_TOPICS_DEF];
    logic [rtu_pkg::MaskW-1:0] fwd_tbl [rtu_pkg::NUM_TOPICS_DEF];
    logic [rtu_pkg::MaskW-1:0] nbr_bits;
    logic [rtu_pkg::MaskW-1:0] sub_kind_bits;

    out_msg_t pending_msgs[$];
    int       mismatch_count;
    int       quiet_cycles;
    bit       stall_en;
    int       hold_len;

    pubsub_broker_routing_table_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .topic       (topic),
        .source_node (source_node),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dest_node   (dest_node),
        .out_kind    (out_kind),
        .out_topic   (out_topic),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    // append one expected item at the tail of the queue
    function automatic void add_pending(input out_msg_t msg);
        pending_msgs.insert(pending_msgs.size(), msg);
    endfunction

    // one item per set bit, ascending node id; tail marks the final segment
    function automatic void push_fanout(input logic [rtu_pkg::MaskW-1:0] m,
                                        input rtu_pkg::kind_t k,
                                        input logic [rtu_pkg::TopicW-1:0] t,
                                        input bit tail);
        int       top_node;
        out_msg_t msg;
        top_node = -1;
        for (int i = 0; i < rtu_pkg::MaskW; i++)
            if (m[i])
                top_node = i;
        for (int i = 0; i < rtu_pkg::MaskW; i++)
        begin
            if (m[i])
            begin
                msg.dest    = i[rtu_pkg::NodeW-1:0];
                msg.kind    = k;
                msg.topic   = t;
                msg.is_last = tail && (i == top_node);
                add_pending(msg);
            end
        end
    endfunction

    function automatic void route_message(input logic [rtu_pkg::CmdW-1:0] c,
                                          input logic [rtu_pkg::TopicW-1:0] t,
                                          input logic [rtu_pkg::NodeW-1:0] s);
        logic [rtu_pkg::MaskW-1:0] src_bit;
        logic [rtu_pkg::MaskW-1:0] fwd;
        out_msg_t                  msg;
        src_bit = 8'd1 << s;
        if (c == rtu_pkg::CMD_PUBLISH)
        begin
            fwd = fwd_tbl[t] & ~src_bit;
            push_fanout(sub_tbl[t], rtu_pkg::KIND_NOTIFY, t, fwd == 0);
            push_fanout(fwd, rtu_pkg::KIND_PUBLISH, t, 1'b1);
        end
        else if (c == rtu_pkg::CMD_SUBSCRIBE && (nbr_bits & src_bit) != 0)
        begin
            if ((sub_kind_bits & src_bit) != 0)
                sub_tbl[t] = sub_tbl[t] | src_bit;
            else
                fwd_tbl[t] = fwd_tbl[t] | src_bit;
            push_fanout(nbr_bits & ~src_bit, rtu_pkg::KIND_SUBSCRIBE, t, 1'b1);
        end
        else
        begin
            msg.dest    = s;
            msg.kind    = rtu_pkg::KIND_ERROR;
            msg.topic   = t;
            msg.is_last = 1'b1;
            add_pending(msg);
        end
    endfunction

    task automatic send_item(input logic [rtu_pkg::CmdW-1:0] c,
                             input logic [rtu_pkg::TopicW-1:0] t,
                             input logic [rtu_pkg::NodeW-1:0] s);
        if (stall_en && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        in_valid    = 1'b1;
        cmd         = c;
        topic       = t;
        source_node = s;
        do @(posedge clk); while (!in_ready);
        route_message(c, t, s);
    endtask

    // drop valid, let every expected item arrive, then let the back end settle
    task automatic wait_quiet();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [rtu_pkg::MaskW-1:0] val);
        wait_quiet();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == rtu_pkg::REG_NEIGHBOR_MASK)
            nbr_bits = val;
        else
            sub_kind_bits = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_random_item();
        logic [rtu_pkg::CmdW-1:0]   c;
        logic [rtu_pkg::TopicW-1:0] t;
        logic [rtu_pkg::NodeW-1:0]  s;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = rtu_pkg::CMD_SUBSCRIBE;
        else if (pick < 88)
            c = rtu_pkg::CMD_PUBLISH;
        else
            c = $urandom_range(0, 1) ? CMD_BAD_HI : CMD_BAD_LO;
        t = rtu_pkg::TopicW'($urandom_range(0, 15));
        s = rtu_pkg::NodeW'($urandom_range(0, 7));
        // mostly pick a real neighbor so subscribes get recorded
        if (nbr_bits != 0 && $urandom_range(0, 3) != 0)
            while (!nbr_bits[s])
                s = rtu_pkg::NodeW'($urandom_range(0, 7));
        send_item(c, t, s);
    endtask

    task automatic test_power_on_defaults();
        send_item(rtu_pkg::CMD_PUBLISH, 4'd0, 3'd0);
        send_item(rtu_pkg::CMD_PUBLISH, 4'd15, 3'd7);
        send_item(rtu_pkg::CMD_SUBSCRIBE, 4'd0, 3'd0);
        send_item(CMD_BAD_LO, 4'd15, 3'd7);
        send_item(CMD_BAD_HI, 4'd9, 3'd5);
    endtask

    task automatic test_subscribe_flood();
        write_reg(rtu_pkg::REG_NEIGHBOR_MASK, 8'hFF);
        write_reg(rtu_pkg::REG_SUB_KIND_MASK, 8'hAA);
        for (int n = 0; n < 8; n++)
            send_item(rtu_pkg::CMD_SUBSCRIBE, 4'd5, n[rtu_pkg::NodeW-1:0]);
        // repeated subscription is recorded once
        send_item(rtu_pkg::CMD_SUBSCRIBE, 4'd5, 3'd3);
    endtask

    task automatic test_publish_fanout();
        send_item(rtu_pkg::CMD_PUBLISH, 4'd5, 3'd0);
        send_item(rtu_pkg::CMD_PUBLISH, 4'd5, 3'd7);
        send_item(rtu_pkg::CMD_PUBLISH, 4'd5, 3'd3);
        send_item(rtu_pkg::CMD_PUBLISH, 4'd15, 3'd4);
    endtask

    task automatic test_lone_neighbor();
        write_reg(rtu_pkg::REG_NEIGHBOR_MASK, 8'h01);
        write_reg(rtu_pkg::REG_SUB_KIND_MASK, 8'h00);
        send_item(rtu_pkg::CMD_SUBSCRIBE, 4'd15, 3'd0);
        send_item(rtu_pkg::CMD_SUBSCRIBE, 4'd15, 3'd1);
        send_item(rtu_pkg::CMD_PUBLISH, 4'd15, 3'd0);
        send_item(rtu_pkg::CMD_PUBLISH, 4'd15, 3'd3);
        // dropping all neighbors keeps recorded routes
        write_reg(rtu_pkg::REG_NEIGHBOR_MASK, 8'h00);
        send_item(rtu_pkg::CMD_PUBLISH, 4'd5, 3'd2);
    endtask

    task automatic test_random_traffic();
        logic [rtu_pkg::MaskW-1:0] nbr_set  [5];
        logic [rtu_pkg::MaskW-1:0] kind_set [5];
        nbr_set  = '{8'hFF, 8'hFF, 8'h5A, 8'h00, 8'h81};
        kind_set = '{8'h00, 8'hFF, 8'h0F, 8'h00, 8'h80};
        nbr_set[3]  = rtu_pkg::MaskW'($urandom_range(0, 255));
        kind_set[3] = rtu_pkg::MaskW'($urandom_range(0, 255));
        for (int p = 0; p < 5; p++)
        begin
            write_reg(rtu_pkg::REG_NEIGHBOR_MASK, nbr_set[p]);
            write_reg(rtu_pkg::REG_SUB_KIND_MASK, kind_set[p]);
            for (int i = 0; i < 60; i++)
                send_random_item();
        end
    endtask

    task automatic test_backpressure();
        write_reg(rtu_pkg::REG_NEIGHBOR_MASK, 8'hFF);
        write_reg(rtu_pkg::REG_SUB_KIND_MASK, 8'h33);
        // receiver holds off while items keep coming, filling the job queue
        hold_len = HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
            send_random_item();
        wait_quiet();
        for (int i = 0; i < 10; i++)
            send_random_item();
    endtask

    task automatic test_steady_stream();
        wait_quiet();
        stall_en = 1'b0;
        for (int i = 0; i < 30; i++)
            send_random_item();
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
                out_ready = 1'b0;
                for (int i = 1; i < n; i++)
                    @(negedge clk);
            end
            else if (stall_en && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        out_msg_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_msgs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected item: dest %0d kind %0d topic %0d last %0d",
                             dest_node, out_kind, out_topic, last_of_run);
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (dest_node !== want.dest || out_kind !== want.kind
                    || out_topic !== want.topic || last_of_run !== want.is_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"item mismatch: expected dest %0d kind %0d topic %0d ",
                                  "last %0d, got dest %0d kind %0d topic %0d last %0d"},
                                 want.dest, want.kind, want.topic, want.is_last,
                                 dest_node, out_kind, out_topic, last_of_run);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = rtu_pkg::REG_NEIGHBOR_MASK;
        cfg_data       = '0;
        in_valid       = 1'b0;
        cmd            = rtu_pkg::CMD_PUBLISH;
        topic          = '0;
        source_node    = '0;
        nbr_bits       = '0;
        sub_kind_bits  = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        stall_en       = 1'b1;
        hold_len       = 0;
        for (int i = 0; i < rtu_pkg::NUM_TOPICS_DEF; i++)
        begin
            sub_tbl[i] = '0;
            fwd_tbl[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_power_on_defaults();
        test_subscribe_flood();
        test_publish_fanout();
        test_lone_neighbor();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();
        wait_quiet();

        if (mismatch_count == 0 && pending_msgs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
